>>> sv/rmsn_pkg.sv
// rmsn_pkg: shared constants and types for the RMS row normalizer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package rmsn_pkg;

    localparam int MAX_ROW_DEF = 64;
    localparam int EPS_W       = 24;
    localparam logic [EPS_W-1:0] EPS_RESET = 24'd168;
    localparam int INV_W       = 43;
    localparam int INV_NUM_MSB = 58;
    localparam int MUL_A_W     = 22;
    localparam int MUL_B_W     = 17;
    localparam int ACC_W       = 62;
    localparam int P_W         = 44;
    localparam int STEP_W      = 7;
    localparam int APB_AW      = 3;
    localparam logic [APB_AW-1:0] ADDR_EPS = 3'd0;

    typedef logic signed [15:0] q412_t;

    typedef struct packed {
        q412_t value;
        q412_t weight;
    } elem_t;

    typedef struct packed {
        logic  en;
        elem_t data;
    } mem_wr_t;

endpackage

>>> sv/rmsn_if.sv
// rmsn_if: valid/ready stream interfaces for input and result transfers.
// Depends on nothing.
`timescale 1ns / 1ps

interface rmsn_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_value;
    logic signed [15:0] column_weight;
    logic               row_end;
    modport source (output valid, output sample_value, output column_weight,
                    output row_end, input ready);
    modport sink (input valid, input sample_value, input column_weight,
                  input row_end, output ready);
endinterface

interface rmsn_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] normalized_value;
    logic               last_of_row;
    logic               truncated;
    modport source (output valid, output normalized_value, output last_of_row,
                    output truncated, input ready);
    modport sink (input valid, input normalized_value, input last_of_row,
                  input truncated, output ready);
endinterface

>>> sv/rms_row_normalizer.sv
// rms_row_normalizer: top level, APB epsilon register, front, queue and back.
// Depends on rmsn_pkg, rmsn_if, rmsn_front, rmsn_fifo, rmsn_back.
// Loading takes one element per cycle into the row store while the front is ready.
// At the row end the back runs an SW-bit restoring divide for the mean square
// (SW = 31 + clog2(MAX_ROW+1), 38 at 64), epsilon add, RW-bit square root (RW =
// (SW+34)/2) and inverse divide, then per result read, load, multiply, round,
// multiply and output on one shared 22x17 multiplier. The front takes the next
// row's first element only once the back has drained the single-row store.
`timescale 1ns / 1ps

module rms_row_normalizer import rmsn_pkg::*; #(
    parameter int MAX_ROW = MAX_ROW_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    rmsn_in_if.sink           in_ch,
    rmsn_out_if.source        out_ch
);

    localparam int CW = $clog2(MAX_ROW + 1);
    localparam int SW = 31 + CW;
    localparam int AW = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1;

    logic [EPS_W-1:0] eps_reg;
    mem_wr_t          wr;
    logic [AW-1:0]    wr_addr;
    logic             push, full, pop, pop_valid, row_done;
    logic [SW+CW:0]   push_data, pop_data;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_EPS) ? 32'(eps_reg) : 32'h0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= EPS_RESET;
        end
        else if (psel && penable && pwrite && paddr == ADDR_EPS)
        begin
            eps_reg <= pwdata[EPS_W-1:0];
        end
    end

    rmsn_front #(.MAX_ROW(MAX_ROW), .CW(CW), .SW(SW), .AW(AW)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .wr        (wr),
        .wr_addr   (wr_addr),
        .push      (push),
        .push_data (push_data),
        .fifo_full (full),
        .row_done  (row_done)
    );

    rmsn_fifo #(.W(SW + CW + 1)) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_data  (pop_data)
    );

    rmsn_back #(.MAX_ROW(MAX_ROW), .CW(CW), .SW(SW), .AW(AW)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (wr),
        .wr_addr    (wr_addr),
        .desc_valid (pop_valid),
        .desc_data  (pop_data),
        .desc_pop   (pop),
        .eps        (eps_reg),
        .row_done   (row_done),
        .out_ch     (out_ch)
    );

endmodule

>>> sv/rmsn_front.sv
// rmsn_front: accepts elements, writes the row store, sums squares and counts.
// Depends on rmsn_pkg and rmsn_in_if.
`timescale 1ns / 1ps

module rmsn_front import rmsn_pkg::*; #(
    parameter int MAX_ROW = MAX_ROW_DEF,
    parameter int CW      = 7,
    parameter int SW      = 38,
    parameter int AW      = 6
) (
    input  logic           clk,
    input  logic           rst_n,
    rmsn_in_if.sink        in_ch,
    output mem_wr_t        wr,
    output logic [AW-1:0]  wr_addr,
    output logic           push,
    output logic [SW+CW:0] push_data,
    input  logic           fifo_full,
    input  logic           row_done
);

    logic [SW-1:0] sum_reg, sum_next, sum_upd;
    logic [CW-1:0] count_reg, count_next, count_upd;
    logic          ovf_reg, ovf_next, ovf_upd;
    logic          hold_reg, hold_next;
    logic          accept, room;
    logic signed [31:0] sq;

    assign in_ch.ready = !hold_reg && !fifo_full;
    assign accept      = in_ch.valid && in_ch.ready;
    assign room        = count_reg < CW'(MAX_ROW);
    assign sq          = in_ch.sample_value * in_ch.sample_value;

    assign wr.en          = accept && room;
    assign wr.data.value  = in_ch.sample_value;
    assign wr.data.weight = in_ch.column_weight;
    assign wr_addr        = count_reg[AW-1:0];

    always_comb
    begin
        sum_upd   = sum_reg;
        count_upd = count_reg;
        ovf_upd   = ovf_reg;
        if (accept)
        begin
            if (room)
            begin
                sum_upd   = sum_reg + SW'($unsigned(sq));
                count_upd = count_reg + CW'(1);
            end
            else
            begin
                ovf_upd = 1'b1;
            end
        end
        sum_next   = sum_upd;
        count_next = count_upd;
        ovf_next   = ovf_upd;
        hold_next  = hold_reg && !row_done;
        push       = 1'b0;
        push_data  = {sum_upd, count_upd, ovf_upd};
        if (accept && in_ch.row_end)
        begin
            push       = 1'b1;
            sum_next   = '0;
            count_next = '0;
            ovf_next   = 1'b0;
            hold_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            hold_reg  <= 1'b0;
        end
        else
        begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            hold_reg  <= hold_next;
        end
    end

endmodule

>>> sv/rmsn_fifo.sv
// rmsn_fifo: small queue of row descriptors between front and back.
// Depends on rmsn_pkg.
`timescale 1ns / 1ps

module rmsn_fifo import rmsn_pkg::*; #(
    parameter int W = 46
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic         pop_valid,
    output logic [W-1:0] pop_data
);

    logic [W-1:0] mem_reg [2];
    logic         wptr_reg, rptr_reg;
    logic [1:0]   cnt_reg;

    assign full      = cnt_reg == 2'd2;
    assign pop_valid = cnt_reg != 2'd0;
    assign pop_data  = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push && !full)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (pop && pop_valid)
            begin
                rptr_reg <= !rptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push && !full) - 2'(pop && pop_valid);
        end
    end

endmodule

>>> sv/rmsn_back.sv
// rmsn_back: row store, mean-square divide, square root, inverse and emission.
// Depends on rmsn_pkg and rmsn_out_if.
`timescale 1ns / 1ps

module rmsn_back import rmsn_pkg::*; #(
    parameter int MAX_ROW = MAX_ROW_DEF,
    parameter int CW      = 7,
    parameter int SW      = 38,
    parameter int AW      = 6
) (
    input  logic             clk,
    input  logic             rst_n,
    input  mem_wr_t          wr,
    input  logic [AW-1:0]    wr_addr,
    input  logic             desc_valid,
    input  logic [SW+CW:0]   desc_data,
    output logic             desc_pop,
    input  logic [EPS_W-1:0] eps,
    output logic             row_done,
    rmsn_out_if.source       out_ch
);

    localparam int DW = SW + 1;
    localparam int RW = (DW + 33) / 2;
    localparam int XW = 2 * RW;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DIV  = 4'd1;
    localparam logic [3:0] S_EPS  = 4'd2;
    localparam logic [3:0] S_SQRT = 4'd3;
    localparam logic [3:0] S_INV  = 4'd4;
    localparam logic [3:0] S_RD   = 4'd5;
    localparam logic [3:0] S_LD   = 4'd6;
    localparam logic [3:0] S_M0   = 4'd7;
    localparam logic [3:0] S_M1   = 4'd8;
    localparam logic [3:0] S_P    = 4'd9;
    localparam logic [3:0] S_M2   = 4'd10;
    localparam logic [3:0] S_M3   = 4'd11;
    localparam logic [3:0] S_OUT  = 4'd12;

    elem_t mem [MAX_ROW];
    elem_t rdata_reg;

    logic [3:0]         state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [SW-1:0]      dvd_reg, dvd_next;
    logic [CW-1:0]      rem_reg, rem_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               ovf_reg, ovf_next;
    logic [XW-1:0]      x_reg, x_next, r_reg, r_next, bit_reg, bit_next;
    logic [RW:0]        rem2_reg, rem2_next;
    logic [INV_W-1:0]   inv_reg, inv_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [16:0]        mv_reg, mv_next, mw_reg, mw_next;
    logic               neg_reg, neg_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [P_W-1:0]     p_reg, p_next;
    logic               ov_reg, ov_next;
    logic [15:0]        od_reg, od_next;
    logic               ol_reg, ol_next, ot_reg, ot_next;

    logic [CW:0]          trial;
    logic [DW-1:0]        d_sum;
    logic [XW-1:0]        rb;
    logic [RW+1:0]        trial2;
    logic [MUL_A_W-1:0]   mul_a;
    logic [MUL_B_W-1:0]   mul_b;
    logic [MUL_A_W+MUL_B_W-1:0] prod;
    logic [ACC_W-1:0]     rnd_p, rnd_q;
    logic [35:0]          q;
    logic [15:0]          qv;
    logic                 slot_free, is_last;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr_addr] <= wr.data;
        end
        rdata_reg <= mem[idx_reg[AW-1:0]];
    end

    assign slot_free = !ov_reg || out_ch.ready;
    assign is_last   = idx_reg == cnt_reg - CW'(1);
    assign trial     = {rem_reg, dvd_reg[SW-1]};
    assign d_sum     = DW'(dvd_reg) + DW'(eps);
    assign rb        = r_reg + bit_reg;
    assign trial2    = {rem2_reg, step_reg == STEP_W'(INV_NUM_MSB)};
    assign prod      = mul_a * mul_b;
    assign rnd_p     = acc_reg + ACC_W'(1 << 15);
    assign rnd_q     = acc_reg + ACC_W'(1 << 25);
    assign q         = rnd_q[61:26];

    always_comb
    begin
        mul_b = mv_reg;
        case (state_reg)
            S_M0:    mul_a = inv_reg[21:0];
            S_M1:    mul_a = {1'b0, inv_reg[42:22]};
            S_M2:    mul_a = p_reg[21:0];
            S_M3:    mul_a = p_reg[43:22];
            default: mul_a = inv_reg[21:0];
        endcase
        if (state_reg == S_M2 || state_reg == S_M3)
        begin
            mul_b = mw_reg;
        end
    end

    always_comb
    begin
        if (neg_reg)
        begin
            qv = (q >= 36'd32768) ? 16'h8000 : (~q[15:0] + 16'd1);
        end
        else
        begin
            qv = (q > 36'd32767) ? 16'h7fff : q[15:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        x_next     = x_reg;
        r_next     = r_reg;
        bit_next   = bit_reg;
        rem2_next  = rem2_reg;
        inv_next   = inv_reg;
        idx_next   = idx_reg;
        mv_next    = mv_reg;
        mw_next    = mw_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        p_next     = p_reg;
        ov_next    = ov_reg && !out_ch.ready;
        od_next    = od_reg;
        ol_next    = ol_reg;
        ot_next    = ot_reg;
        desc_pop   = 1'b0;
        row_done   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (desc_valid)
                begin
                    desc_pop   = 1'b1;
                    dvd_next   = desc_data[SW+CW:CW+1];
                    cnt_next   = desc_data[CW:1];
                    ovf_next   = desc_data[0];
                    rem_next   = '0;
                    step_next  = STEP_W'(SW);
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (trial >= {1'b0, cnt_reg})
                begin
                    rem_next = CW'(trial - {1'b0, cnt_reg});
                    dvd_next = {dvd_reg[SW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[CW-1:0];
                    dvd_next = {dvd_reg[SW-2:0], 1'b0};
                end
                step_next = step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                begin
                    state_next = S_EPS;
                end
            end
            S_EPS:
            begin
                x_next     = XW'({((d_sum == '0) ? DW'(1) : d_sum), 32'h0});
                r_next     = '0;
                bit_next   = XW'(1) << (XW - 2);
                step_next  = STEP_W'(RW);
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                if (x_reg >= rb)
                begin
                    x_next = x_reg - rb;
                    r_next = (r_reg >> 1) + bit_reg;
                end
                else
                begin
                    r_next = r_reg >> 1;
                end
                bit_next  = bit_reg >> 2;
                step_next = step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                begin
                    rem2_next  = '0;
                    inv_next   = '0;
                    step_next  = STEP_W'(INV_NUM_MSB);
                    state_next = S_INV;
                end
            end
            S_INV:
            begin
                if (trial2 >= {1'b0, r_reg[RW:0]})
                begin
                    rem2_next = (RW+1)'(trial2 - {1'b0, r_reg[RW:0]});
                    inv_next  = {inv_reg[INV_W-2:0], 1'b1};
                end
                else
                begin
                    rem2_next = trial2[RW:0];
                    inv_next  = {inv_reg[INV_W-2:0], 1'b0};
                end
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    idx_next   = '0;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_LD;
            end
            S_LD:
            begin
                mv_next    = rdata_reg.value[15] ? 17'(-{1'b1, rdata_reg.value})
                                                 : {1'b0, rdata_reg.value};
                mw_next    = rdata_reg.weight[15] ? 17'(-{1'b1, rdata_reg.weight})
                                                  : {1'b0, rdata_reg.weight};
                neg_next   = rdata_reg.value[15] != rdata_reg.weight[15];
                state_next = S_M0;
            end
            S_M0:
            begin
                acc_next   = ACC_W'(prod);
                state_next = S_M1;
            end
            S_M1:
            begin
                acc_next   = acc_reg + (ACC_W'(prod) << 22);
                state_next = S_P;
            end
            S_P:
            begin
                p_next     = rnd_p[59:16];
                state_next = S_M2;
            end
            S_M2:
            begin
                acc_next   = ACC_W'(prod);
                state_next = S_M3;
            end
            S_M3:
            begin
                acc_next   = acc_reg + (ACC_W'(prod) << 22);
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (slot_free)
                begin
                    ov_next = 1'b1;
                    od_next = qv;
                    ol_next = is_last;
                    ot_next = ovf_reg;
                    if (is_last)
                    begin
                        row_done   = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + CW'(1);
                        state_next = S_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
        ovf_reg  <= ovf_next;
        x_reg    <= x_next;
        r_reg    <= r_next;
        bit_reg  <= bit_next;
        rem2_reg <= rem2_next;
        inv_reg  <= inv_next;
        idx_reg  <= idx_next;
        mv_reg   <= mv_next;
        mw_reg   <= mw_next;
        neg_reg  <= neg_next;
        acc_reg  <= acc_next;
        p_reg    <= p_next;
        od_reg   <= od_next;
        ol_reg   <= ol_next;
        ot_reg   <= ot_next;
    end

    assign out_ch.valid            = ov_reg;
    assign out_ch.normalized_value = od_reg;
    assign out_ch.last_of_row      = ol_reg;
    assign out_ch.truncated        = ot_reg;

    a_desc_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        desc_pop |-> desc_data[CW:1] != '0)
        else $error("row descriptor with zero count");

    a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INV) |-> r_reg[XW-1:16] != '0)
        else $error("square root below one");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |-> idx_reg < cnt_reg)
        else $error("emit index past row length");

endmodule
